// ===== hdl/sch_pkg.sv =====
// ----------------------------------------------------------------------------
// sch_pkg
// Shared types, constants and helpers of the substring count histogram.
// ----------------------------------------------------------------------------
package sch_pkg;

  localparam int MAX_PATTERN   = 19;
  localparam int PAT_REG_BYTES = 19;
  localparam int HIST_BINS     = 64;
  localparam int BIN_W         = $clog2(HIST_BINS);
  localparam int TOTAL_W       = 16;
  localparam int LEN_W         = 5;
  localparam int CHAR_W        = 8;
  localparam int CFG_W         = 64;
  localparam int CFG_IDX_W     = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_PAT_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAT_MID  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PAT_HIGH = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PAT_LEN  = 2'd3;

  localparam logic [1:0] MODE_CHAR   = 2'd0;
  localparam logic [1:0] MODE_END    = 2'd1;
  localparam logic [1:0] MODE_REPORT = 2'd2;

  localparam logic [LEN_W-1:0]   LEN_MAX   = LEN_W'(MAX_PATTERN);
  localparam logic [LEN_W-1:0]   CHAR_SAT  = '1;
  localparam logic [BIN_W-1:0]   BIN_TOP   = BIN_W'(HIST_BINS - 1);
  localparam logic [TOTAL_W-1:0] TOTAL_SAT = '1;

  typedef struct packed {
    logic [1:0]        mode;
    logic [CHAR_W-1:0] char_byte;
  } in_item_t;

  typedef struct packed {
    logic [BIN_W-1:0]   occurrences;
    logic [TOTAL_W-1:0] sentence_total;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic             upd;
    logic             rep;
    logic [BIN_W-1:0] bin;
  } hist_cmd_t;

  function automatic logic [CHAR_W-1:0] pat_byte(input logic [63:0] low,
                                                 input logic [63:0] mid,
                                                 input logic [23:0] high,
                                                 input logic [LEN_W-1:0] idx);
    logic [CHAR_W-1:0] res;
    res = '0;
    if (idx < LEN_W'(8)) begin
      res = low[{idx[2:0], 3'b000} +: CHAR_W];
    end else if (idx < LEN_W'(16)) begin
      res = mid[{idx[2:0], 3'b000} +: CHAR_W];
    end else if (idx < LEN_W'(PAT_REG_BYTES)) begin
      res = high[{idx[1:0], 3'b000} +: CHAR_W];
    end
    return res;
  endfunction

endpackage

// ===== hdl/sch_cell.sv =====
// ----------------------------------------------------------------------------
// sch_cell
// One window cell: holds a character, shifts it on, and extends the match.
// ----------------------------------------------------------------------------
module sch_cell (
  input  logic                       clk,
  input  logic                       shift_en,
  input  logic                       care,
  input  logic [sch_pkg::CHAR_W-1:0] exp_byte,
  input  logic [sch_pkg::CHAR_W-1:0] char_in,
  input  logic                       match_in,
  output logic [sch_pkg::CHAR_W-1:0] char_out,
  output logic                       match_out
);
  import sch_pkg::*;

  logic [CHAR_W-1:0] char_r;
  logic [CHAR_W-1:0] char_nxt;

  // The match looks at the character this cell takes on the current shift.
  assign char_nxt  = shift_en ? char_in : char_r;
  assign match_out = match_in & (~care | (char_in == exp_byte));
  assign char_out  = char_r;

  always_ff @(posedge clk) begin
    char_r <= char_nxt;
  end

endmodule

// ===== hdl/sch_hist.sv =====
// ----------------------------------------------------------------------------
// sch_hist
// Histogram memory with bin update and report walk.
// ----------------------------------------------------------------------------
module sch_hist (
  input  logic               clk,
  input  logic               rst_n,
  input  sch_pkg::hist_cmd_t cmd,
  output logic               busy,
  output logic               out_valid,
  input  logic               out_stall,
  output sch_pkg::out_item_t out_data
);
  import sch_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_UPD_RD = 3'd1;
  localparam logic [2:0] ST_UPD_WR = 3'd2;
  localparam logic [2:0] ST_REP_RD = 3'd3;
  localparam logic [2:0] ST_REP_OUT = 3'd4;

  logic [TOTAL_W-1:0]   mem [HIST_BINS];
  logic [HIST_BINS-1:0] vld_r;
  logic [HIST_BINS-1:0] vld_nxt;
  logic [2:0]           state_r;
  logic [2:0]           state_nxt;
  logic [BIN_W-1:0]     cur_r;
  logic [BIN_W-1:0]     cur_nxt;
  logic [BIN_W-1:0]     top_r;
  logic [BIN_W-1:0]     top_nxt;
  logic [BIN_W-1:0]     largest_r;
  logic [BIN_W-1:0]     largest_nxt;
  logic [TOTAL_W-1:0]   rd_data_r;
  logic                 rd_vld_r;
  logic [TOTAL_W-1:0]   total;
  logic [TOTAL_W-1:0]   total_inc;
  logic                 wr_en;

  assign total     = rd_vld_r ? rd_data_r : '0;
  assign total_inc = (total == TOTAL_SAT) ? total : total + TOTAL_W'(1);
  assign wr_en     = (state_r == ST_UPD_WR);

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_REP_OUT);
  assign out_data  = '{occurrences: cur_r, sentence_total: total, last: (cur_r == top_r)};

  always_comb begin
    state_nxt   = state_r;
    cur_nxt     = cur_r;
    top_nxt     = top_r;
    largest_nxt = largest_r;
    vld_nxt     = vld_r;
    case (state_r)
      ST_IDLE: begin
        if (cmd.upd) begin
          cur_nxt   = cmd.bin;
          state_nxt = ST_UPD_RD;
        end else if (cmd.rep) begin
          cur_nxt   = '0;
          top_nxt   = largest_r;
          state_nxt = ST_REP_RD;
        end
      end
      ST_UPD_RD: begin
        state_nxt = ST_UPD_WR;
      end
      ST_UPD_WR: begin
        vld_nxt[cur_r] = 1'b1;
        if (cur_r > largest_r) begin
          largest_nxt = cur_r;
        end
        state_nxt = ST_IDLE;
      end
      ST_REP_RD: begin
        state_nxt = ST_REP_OUT;
      end
      ST_REP_OUT: begin
        if (!out_stall) begin
          if (cur_r == top_r) begin
            state_nxt = ST_IDLE;
          end else begin
            cur_nxt   = cur_r + BIN_W'(1);
            state_nxt = ST_REP_RD;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      vld_r     <= '0;
      largest_r <= '0;
      cur_r     <= '0;
      top_r     <= '0;
    end else begin
      state_r   <= state_nxt;
      vld_r     <= vld_nxt;
      largest_r <= largest_nxt;
      cur_r     <= cur_nxt;
      top_r     <= top_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[cur_r];
    rd_vld_r  <= vld_r[cur_r];
    if (wr_en) begin
      mem[cur_r] <= total_inc;
    end
  end

endmodule

// ===== hdl/substring_count_histogram.sv =====
// ----------------------------------------------------------------------------
// substring_count_histogram
// Counts pattern matches per sentence and keeps a histogram of the counts.
// ----------------------------------------------------------------------------
//   Channel  Direction  Carries
//   in_      input      mode and character of one transaction
//   out_     output     one histogram bin per transaction
//   cfg_     input      pattern bytes and pattern length writes
//
// Characters stream at full rate while in_stall is low. An end-of-sentence
// transaction passes through a read and then a write of the single-port
// histogram memory. A report makes one memory read per bin, from bin 0 up to
// the largest bin updated so far. Reset is synchronous and clears the
// histogram through per-bin valid bits. in_stall is high while an update or
// a report is in progress; a stalled report bin holds until taken.
module substring_count_histogram (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  sch_pkg::in_item_t             in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output sch_pkg::out_item_t            out_data,
  input  logic                          cfg_we,
  input  logic [sch_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sch_pkg::CFG_W-1:0]     cfg_wdata
);
  import sch_pkg::*;

  logic [63:0]       pat_low_r;
  logic [63:0]       pat_mid_r;
  logic [23:0]       pat_high_r;
  logic [LEN_W-1:0]  pat_len_r;
  logic [LEN_W-1:0]  len_eff;
  logic [LEN_W-1:0]  cnt_r;
  logic [LEN_W-1:0]  cnt_nxt;
  logic [LEN_W-1:0]  cnt_inc;
  logic [BIN_W-1:0]  sm_r;
  logic [BIN_W-1:0]  sm_nxt;
  logic [BIN_W-1:0]  sm_eff;
  logic              hit_r;
  logic              hit_nxt;
  logic              in_acc;
  logic              char_acc;
  logic              end_acc;
  logic              hit;
  logic [CHAR_W-1:0] chain [MAX_PATTERN+1];
  logic              mchain [MAX_PATTERN+1];
  hist_cmd_t         cmd;

  assign in_acc   = in_valid & ~in_stall;
  assign char_acc = in_acc & (in_data.mode == MODE_CHAR);
  assign end_acc  = in_acc & (in_data.mode == MODE_END);
  assign len_eff  = (pat_len_r > LEN_MAX) ? LEN_MAX : pat_len_r;
  assign cnt_inc  = (cnt_r == CHAR_SAT) ? cnt_r : cnt_r + LEN_W'(1);
  assign sm_eff   = (hit_r && (sm_r != BIN_TOP)) ? sm_r + BIN_W'(1) : sm_r;

  assign chain[0]  = in_data.char_byte;
  assign mchain[0] = 1'b1;

  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
    logic              care;
    logic [CHAR_W-1:0] exp_byte;
    assign care     = (LEN_W'(k) < len_eff);
    assign exp_byte = pat_byte(pat_low_r, pat_mid_r, pat_high_r,
                               LEN_W'(len_eff - LEN_W'(k) - LEN_W'(1)));
    sch_cell u_cell (
      .clk       (clk),
      .shift_en  (char_acc),
      .care      (care),
      .exp_byte  (exp_byte),
      .char_in   (chain[k]),
      .match_in  (mchain[k]),
      .char_out  (chain[k+1]),
      .match_out (mchain[k+1])
    );
  end

  assign hit = mchain[MAX_PATTERN] & (len_eff != '0) & (cnt_inc >= len_eff);

  always_comb begin
    cnt_nxt = cnt_r;
    sm_nxt  = sm_eff;
    hit_nxt = 1'b0;
    if (char_acc) begin
      cnt_nxt = cnt_inc;
      hit_nxt = hit;
    end else if (end_acc) begin
      cnt_nxt = '0;
      sm_nxt  = '0;
    end
  end

  assign cmd = '{upd: end_acc,
                 rep: in_acc & (in_data.mode == MODE_REPORT),
                 bin: sm_eff};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r      <= '0;
      sm_r       <= '0;
      hit_r      <= 1'b0;
      pat_low_r  <= '0;
      pat_mid_r  <= '0;
      pat_high_r <= '0;
      pat_len_r  <= LEN_W'(1);
    end else begin
      cnt_r <= cnt_nxt;
      sm_r  <= sm_nxt;
      hit_r <= hit_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_PAT_LOW:  pat_low_r  <= cfg_wdata;
          CFG_PAT_MID:  pat_mid_r  <= cfg_wdata;
          CFG_PAT_HIGH: pat_high_r <= cfg_wdata[23:0];
          CFG_PAT_LEN:  pat_len_r  <= cfg_wdata[LEN_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  sch_hist u_hist (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .busy      (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== hdl/sch_checker.sv =====
// ----------------------------------------------------------------------------
// sch_checker
// Port-level checks of the substring count histogram, bound to the top level.
// ----------------------------------------------------------------------------
module sch_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input sch_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_stall,
  input sch_pkg::out_item_t out_data
);
  import sch_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_report_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input accepted during report");

  a_report_starts_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_data.mode == MODE_REPORT) |=> in_stall)
    else $error("report transaction did not stall input");

  a_bins_ascend: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_data.last |=>
      !out_valid ##1 (out_valid &&
        out_data.occurrences == BIN_W'($past(out_data.occurrences, 2) + BIN_W'(1))))
    else $error("report bins out of sequence");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind substring_count_histogram sch_checker u_sch_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
